// File: rtl/depq_pkg.sv
// shared types, codes and read-out tree sizing for the double-ended priority queue
`timescale 1ns / 1ps

package depq_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP_HI = 2'd1,
        OP_POP_LO = 2'd2
    } t_op;

    // status codes carried in the output tuser
    typedef enum logic [1:0] {
        ST_SERVED = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic pop_lo;
        logic pop_hi;
    } t_cell_ctl;

    // fan-in of one node of the read-out tree
    localparam int FAN_IN = 32;
    localparam int MAX_LVLS = 8;

    // number of nodes at tree level l (level 0 is the leaves)
    function automatic int level_count(input int n, input int l);
        int c;
        c = n;
        for (int i = 0; i < MAX_LVLS; i++) begin
            if (i < l) begin
                c = (c + FAN_IN - 1) / FAN_IN;
            end
        end
        return c;
    endfunction

    // levels needed to reduce n leaves to one root
    function automatic int tree_levels(input int n);
        int c;
        int lv;
        c  = n;
        lv = 0;
        for (int i = 0; i < MAX_LVLS; i++) begin
            if (c > 1) begin
                c  = (c + FAN_IN - 1) / FAN_IN;
                lv = lv + 1;
            end
        end
        return lv;
    endfunction

    // position of level l (from 1) in the flat node array
    function automatic int level_offset(input int n, input int l);
        int off;
        off = 0;
        for (int i = 1; i <= MAX_LVLS; i++) begin
            if (i < l) begin
                off = off + level_count(n, i);
            end
        end
        return off;
    endfunction

endpackage

// File: rtl/double_ended_priority_queue.sv
// top level: sorted cell chain, read-out tree and stream handshake control
// a transaction is taken in S_IDLE; its result passes through the NLVL registered levels
//   of the read-out tree, NLVL = ceil(log32(CAPACITY)) (2 at 1024 entries), then S_SEND
// one transaction at a time: s_axis_tready stays low until the result is taken in S_SEND,
//   or until the read-out tree has drained for an insert that yields none
// reset: synchronous active-low; clears all cell valid bits, so the queue starts empty
`timescale 1ns / 1ps

module double_ended_priority_queue import depq_pkg::*; #(
    parameter int CAPACITY      = 1024,
    parameter int PRIORITY_BITS = 24,
    parameter int ID_BITS       = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // client_id[23:0], priority_req[47:24]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // served_id[23:0]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int TREE_LVLS = tree_levels(CAPACITY);
    localparam int CW        = $clog2(TREE_LVLS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WAIT = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_cnt;
    logic                     r_has_res;
    t_status                  r_status;
    logic [23:0]              r_out_id;
    t_status                  r_out_status;

    logic                     w_accept;
    t_op                      w_op;
    t_cell_ctl                w_ctl;
    logic                     w_res;
    t_status                  w_st;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_sel_hi;
    logic [PRIORITY_BITS-1:0] w_new_pri;
    logic [ID_BITS-1:0]       w_new_id;
    logic [ID_BITS-1:0]       w_root;
    logic [CAPACITY-1:0]      w_valid_vec;

    logic                     w_valid [CAPACITY];
    logic                     w_gt    [CAPACITY];
    logic                     w_top   [CAPACITY];
    logic [PRIORITY_BITS-1:0] w_pri   [CAPACITY];
    logic [ID_BITS-1:0]       w_id    [CAPACITY];
    logic [ID_BITS-1:0]       w_leaf  [CAPACITY];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_new_id      = ID_BITS'(s_axis_tdata[23:0]);
    assign w_new_pri     = PRIORITY_BITS'(s_axis_tdata[47:24]);
    assign w_full        = w_valid[CAPACITY-1];
    assign w_empty       = !w_valid[0];
    assign w_sel_hi      = (w_op == OP_POP_HI);

    always_comb begin
        w_ctl = '0;
        w_res = 1'b0;
        w_st  = ST_SERVED;
        unique case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    w_res = 1'b1;
                    w_st  = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                end
            end
            OP_POP_HI: begin
                w_res = 1'b1;
                if (w_empty) begin
                    w_st = ST_EMPTY;
                end else begin
                    w_ctl.pop_hi = w_accept;
                end
            end
            OP_POP_LO: begin
                w_res = 1'b1;
                if (w_empty) begin
                    w_st = ST_EMPTY;
                end else begin
                    w_ctl.pop_lo = w_accept;
                end
            end
            default: begin
                w_res = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     w_lv;
        logic                     w_lgt;
        logic [PRIORITY_BITS-1:0] w_lpri;
        logic [ID_BITS-1:0]       w_lid;
        logic                     w_rv;
        logic [PRIORITY_BITS-1:0] w_rpri;
        logic [ID_BITS-1:0]       w_rid;
        logic                     w_sel;

        if (g == 0) begin : g_first
            assign w_lv   = 1'b1;
            assign w_lgt  = 1'b0;
            assign w_lpri = '0;
            assign w_lid  = '0;
            assign w_sel  = w_sel_hi ? w_top[g] : 1'b1;
        end else begin : g_mid
            assign w_lv   = w_valid[g-1];
            assign w_lgt  = w_gt[g-1];
            assign w_lpri = w_pri[g-1];
            assign w_lid  = w_id[g-1];
            assign w_sel  = w_sel_hi && w_top[g];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rv   = 1'b0;
            assign w_rpri = '0;
            assign w_rid  = '0;
        end else begin : g_inner
            assign w_rv   = w_valid[g+1];
            assign w_rpri = w_pri[g+1];
            assign w_rid  = w_id[g+1];
        end

        assign w_leaf[g]      = w_sel ? w_id[g] : '0;
        assign w_valid_vec[g] = w_valid[g];

        depq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .ID_BITS       (ID_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_pri     (w_new_pri),
            .i_new_id      (w_new_id),
            .i_left_valid  (w_lv),
            .i_left_gt     (w_lgt),
            .i_left_pri    (w_lpri),
            .i_left_id     (w_lid),
            .i_right_valid (w_rv),
            .i_right_pri   (w_rpri),
            .i_right_id    (w_rid),
            .o_valid       (w_valid[g]),
            .o_gt          (w_gt[g]),
            .o_top         (w_top[g]),
            .o_pri         (w_pri[g]),
            .o_id          (w_id[g])
        );
    end

    // first tree level samples the leaves at the accept edge, before the chain moves
    depq_or_tree #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_has_res <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_has_res <= w_res;
                        r_cnt     <= CW'(TREE_LVLS - 1);
                        r_state   <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (r_cnt == '0) begin
                        r_state <= r_has_res ? S_SEND : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SEND: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_st;
        end
        if (r_state == S_WAIT && r_cnt == '0) begin
            r_out_status <= r_status;
            r_out_id     <= (r_status == ST_SERVED) ? 24'(w_root) : '0;
        end
    end

    assign m_axis_tvalid = (r_state == S_SEND);
    assign m_axis_tdata  = r_out_id;
    assign m_axis_tuser  = r_out_status;

    // occupied cells always form an unbroken run from the low end
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec[CAPACITY-1:1] & ~w_valid_vec[CAPACITY-2:0]) == '0)
        else $error("cell chain has a hole in its occupied run");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> $countones(w_valid_vec) == $past($countones(w_valid_vec)) + 1)
        else $error("insert did not add exactly one entry");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.pop_lo || w_ctl.pop_hi) |=>
            $countones(w_valid_vec) + 1 == $past($countones(w_valid_vec)))
        else $error("pop did not remove exactly one entry");

    a_no_id_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_SERVED) |-> m_axis_tdata == '0)
        else $error("nonzero identifier on an empty or full status");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("new transaction taken while one is still in flight");

endmodule

// File: rtl/depq_cell.sv
// one cell of the sorted chain: holds one entry and trades it with its neighbors
`timescale 1ns / 1ps

module depq_cell import depq_pkg::*; #(
    parameter int PRIORITY_BITS = 24,
    parameter int ID_BITS       = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic [PRIORITY_BITS-1:0] i_new_pri,
    input  logic [ID_BITS-1:0]       i_new_id,
    input  logic                     i_left_valid,
    input  logic                     i_left_gt,
    input  logic [PRIORITY_BITS-1:0] i_left_pri,
    input  logic [ID_BITS-1:0]       i_left_id,
    input  logic                     i_right_valid,
    input  logic [PRIORITY_BITS-1:0] i_right_pri,
    input  logic [ID_BITS-1:0]       i_right_id,
    output logic                     o_valid,
    output logic                     o_gt,
    output logic                     o_top,
    output logic [PRIORITY_BITS-1:0] o_pri,
    output logic [ID_BITS-1:0]       o_id
);

    logic                     r_valid;
    logic [PRIORITY_BITS-1:0] r_pri;
    logic [ID_BITS-1:0]       r_id;
    logic                     n_valid;
    logic [PRIORITY_BITS-1:0] n_pri;
    logic [ID_BITS-1:0]       n_id;

    // strictly greater keeps ties in insertion order
    assign o_gt    = r_valid && (r_pri > i_new_pri);
    assign o_top   = r_valid && !i_right_valid;
    assign o_valid = r_valid;
    assign o_pri   = r_pri;
    assign o_id    = r_id;

    always_comb begin
        n_valid = r_valid;
        n_pri   = r_pri;
        n_id    = r_id;
        if (i_ctl.ins) begin
            if (i_left_gt) begin
                // make room: shift up from the lower neighbor
                n_pri = i_left_pri;
                n_id  = i_left_id;
            end else if ((o_gt || !r_valid) && i_left_valid) begin
                n_pri = i_new_pri;
                n_id  = i_new_id;
            end
            n_valid = r_valid || i_left_valid;
        end else if (i_ctl.pop_lo) begin
            n_pri   = i_right_pri;
            n_id    = i_right_id;
            n_valid = i_right_valid;
        end else if (i_ctl.pop_hi) begin
            n_valid = r_valid && i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_id  <= n_id;
    end

endmodule

// File: rtl/depq_or_tree.sv
// registered or-reduction tree that reads out the one selected cell identifier
`timescale 1ns / 1ps

module depq_or_tree import depq_pkg::*; #(
    parameter int CAPACITY = 1024,
    parameter int ID_BITS  = 24
) (
    input  logic               i_clk,
    input  logic [ID_BITS-1:0] i_leaf [CAPACITY],
    output logic [ID_BITS-1:0] o_root
);

    localparam int NLVL  = tree_levels(CAPACITY);
    localparam int NNODE = level_offset(CAPACITY, NLVL + 1);

    logic [ID_BITS-1:0] r_node [NNODE];

    for (genvar l = 1; l <= NLVL; l++) begin : g_lvl
        localparam int CNT  = level_count(CAPACITY, l);
        localparam int PREV = level_count(CAPACITY, l - 1);
        localparam int OFF  = level_offset(CAPACITY, l);
        localparam int POFF = level_offset(CAPACITY, l - 1);
        for (genvar j = 0; j < CNT; j++) begin : g_node
            logic [ID_BITS-1:0] w_term [FAN_IN];
            logic [ID_BITS-1:0] n_node;
            for (genvar k = 0; k < FAN_IN; k++) begin : g_term
                if (j * FAN_IN + k >= PREV) begin : g_pad
                    assign w_term[k] = '0;
                end else if (l == 1) begin : g_leaf
                    assign w_term[k] = i_leaf[j * FAN_IN + k];
                end else begin : g_inner
                    assign w_term[k] = r_node[POFF + j * FAN_IN + k];
                end
            end
            // at most one leaf is nonzero, so or-ing acts as a mux
            always_comb begin
                n_node = '0;
                for (int k = 0; k < FAN_IN; k++) begin
                    n_node = n_node | w_term[k];
                end
            end
            always_ff @(posedge i_clk) begin
                r_node[OFF + j] <= n_node;
            end
        end
    end

    assign o_root = r_node[level_offset(CAPACITY, NLVL)];

endmodule
